>>> design/virqd_pkg.sv
// virqd_pkg: shared codes, offsets and transfer structs for the virtual irq distributor
// no dependencies; imported by the front, command queue, back end and top level

package virqd_pkg;

	// defaults for the top level parameters
	localparam int NUM_VIRQ_DEF     = 64;
	localparam int PHYS_ID_BITS_DEF = 10;

	// fixed field widths
	localparam int PHYS_IRQ_W  = 10;
	localparam int VIRQ_IDX_W  = 6;
	localparam int CMDQ_DEPTH  = 2;

	// operations
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_MAP    = 2'd2;
	localparam logic [1:0] OP_LOOKUP = 2'd3;

	// result kinds
	localparam logic [2:0] K_READ    = 3'd0;
	localparam logic [2:0] K_FWD_EN  = 3'd1;
	localparam logic [2:0] K_FWD_DIS = 3'd2;
	localparam logic [2:0] K_LOOKUP  = 3'd3;
	localparam logic [2:0] K_DONE    = 3'd4;

	// status codes
	localparam logic [2:0] S_OK          = 3'd0;
	localparam logic [2:0] S_BAD_OFFSET  = 3'd1;
	localparam logic [2:0] S_BOTH_GROUPS = 3'd2;
	localparam logic [2:0] S_BAD_SGI     = 3'd3;
	localparam logic [2:0] S_BANKED      = 3'd4;
	localparam logic [2:0] S_RANGE       = 3'd5;

	// command classes handed from front to back
	localparam logic [2:0] CLS_READ   = 3'd0;
	localparam logic [2:0] CLS_MAP    = 3'd1;
	localparam logic [2:0] CLS_DONE   = 3'd2;
	localparam logic [2:0] CLS_CTRL   = 3'd3;
	localparam logic [2:0] CLS_EN_SET = 3'd4;
	localparam logic [2:0] CLS_EN_CLR = 3'd5;
	localparam logic [2:0] CLS_LOOKUP = 3'd6;

	// register map
	localparam logic [11:0] OFS_CTRL    = 12'h000;
	localparam logic [11:0] OFS_TYPE    = 12'h004;
	localparam logic [11:0] OFS_GROUP   = 12'h080;
	localparam logic [11:0] OFS_SET_LO  = 12'h100;
	localparam logic [11:0] OFS_SET_HI  = 12'h17C;
	localparam logic [11:0] OFS_CLR_LO  = 12'h180;
	localparam logic [11:0] OFS_CLR_HI  = 12'h1FC;
	localparam logic [11:0] OFS_PRIO_LO = 12'h400;
	localparam logic [11:0] OFS_PRIO_HI = 12'h7F8;
	localparam logic [11:0] OFS_TGT_LO  = 12'h800;
	localparam logic [11:0] OFS_TGT_BNK = 12'h81F;
	localparam logic [11:0] OFS_TGT_HI  = 12'h8F8;
	localparam logic [11:0] OFS_CFG_LO  = 12'hC00;
	localparam logic [11:0] OFS_CFG_HI  = 12'hCFC;
	localparam logic [11:0] OFS_SGI     = 12'hF00;

	localparam logic [31:0] TYPE_VALUE = 32'h0000_FC21;

	typedef struct packed {
		logic [2:0]  cls;
		logic [2:0]  status;
		logic [4:0]  word;
		logic [31:0] data;
		logic [5:0]  vid;
		logic [9:0]  pid;
		logic        pid_valid;
	} cmd_t;

	typedef struct packed {
		logic [2:0]            kind;
		logic [2:0]            status;
		logic [31:0]           read_data;
		logic [PHYS_IRQ_W-1:0] phys_irq;
		logic                  found;
		logic [VIRQ_IDX_W-1:0] virq_index;
		logic                  dist_enabled;
		logic                  last;
	} res_t;

endpackage

>>> design/virqd_ram.sv
// virqd_ram: generic single-write, single-read memory with registered read data
// no dependencies

module virqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> design/virqd_cmd_fifo.sv
// virqd_cmd_fifo: short command queue between the classifying front and the back end
// depends on virqd_pkg for cmd_t and the queue depth

module virqd_cmd_fifo
	import virqd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic avail
);

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             mem_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign avail   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && avail;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

>>> design/virqd_front.sv
// virqd_front: accepts input items, decodes the operation and register offset into a command
// depends on virqd_pkg for codes, offsets and cmd_t

module virqd_front
	import virqd_pkg::*;
#(
	parameter int NUM_VIRQ = NUM_VIRQ_DEF
) (
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [11:0] offset,
	input  logic [31:0] data,
	input  logic [5:0]  vid,
	input  logic [9:0]  pid,
	input  logic        pid_valid,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        cmd
);

	localparam int NUM_WORDS = NUM_VIRQ / 32;

	logic [11:0] set_rel;
	logic [11:0] clr_rel;
	logic [4:0]  set_word;
	logic [4:0]  clr_word;

	assign full    = q_full;
	assign q_push  = push && !q_full;
	assign set_rel = offset - OFS_SET_LO;
	assign clr_rel = offset - OFS_CLR_LO;
	assign set_word = set_rel[6:2];
	assign clr_word = clr_rel[6:2];

	always_comb begin
		cmd.cls       = CLS_DONE;
		cmd.status    = S_OK;
		cmd.word      = '0;
		cmd.data      = data;
		cmd.vid       = vid;
		cmd.pid       = pid;
		cmd.pid_valid = pid_valid;
		unique case (operation)
			OP_READ: begin
				cmd.cls    = CLS_READ;
				cmd.status = (offset == OFS_TYPE) ? S_OK : S_BAD_OFFSET;
			end
			OP_MAP: begin
				cmd.cls    = CLS_MAP;
				cmd.status = (32'(vid) < NUM_VIRQ) ? S_OK : S_RANGE;
			end
			OP_LOOKUP: begin
				cmd.cls = CLS_LOOKUP;
			end
			default: begin
				if (offset == OFS_CTRL) begin
					cmd.cls    = CLS_CTRL;
					cmd.status = (data[1:0] == 2'b11) ? S_BOTH_GROUPS : S_OK;
				end else if (offset == OFS_GROUP) begin
					cmd.status = S_OK;
				end else if (offset >= OFS_SET_LO && offset <= OFS_SET_HI) begin
					cmd.word = set_word;
					if (32'(set_word) < NUM_WORDS)
						cmd.cls = CLS_EN_SET;
					else
						cmd.status = S_RANGE;
				end else if (offset >= OFS_CLR_LO && offset <= OFS_CLR_HI) begin
					cmd.word = clr_word;
					if (32'(clr_word) < NUM_WORDS)
						cmd.cls = CLS_EN_CLR;
					else
						cmd.status = S_RANGE;
				end else if (offset >= OFS_PRIO_LO && offset <= OFS_PRIO_HI) begin
					cmd.status = S_OK;
				end else if (offset >= OFS_TGT_LO && offset <= OFS_TGT_HI) begin
					// first eight target words are banked per cpu
					cmd.status = (offset <= OFS_TGT_BNK) ? S_BANKED : S_OK;
				end else if (offset >= OFS_CFG_LO && offset <= OFS_CFG_HI) begin
					cmd.status = S_OK;
				end else if (offset == OFS_SGI) begin
					cmd.status = (data[25:24] == 2'b11) ? S_BAD_SGI : S_OK;
				end else begin
					cmd.status = S_BAD_OFFSET;
				end
			end
		endcase
	end

endmodule

>>> design/virqd_back.sv
// virqd_back: executes commands, holds enable/map state and the phys-id memory, drives results
// depends on virqd_pkg for codes and structs, and on virqd_ram for the phys-id store

module virqd_back
	import virqd_pkg::*;
#(
	parameter int NUM_VIRQ     = NUM_VIRQ_DEF,
	parameter int PHYS_ID_BITS = PHYS_ID_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_avail,
	output logic cmd_pop,
	output res_t res,
	output logic res_valid,
	input  logic res_pop
);

	localparam int VIRQ_W = $clog2(NUM_VIRQ);
	localparam int CNT_W  = VIRQ_W + 1;
	localparam int IW     = (VIRQ_W > VIRQ_IDX_W) ? VIRQ_W : VIRQ_IDX_W;
	localparam int XW     = (PHYS_ID_BITS > PHYS_IRQ_W) ? PHYS_ID_BITS : PHYS_IRQ_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]          state_q, state_d;
	cmd_t                cur_q;
	logic                cur_load;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [CNT_W-1:0]    end_q, end_d;
	logic [CNT_W-1:0]    start;
	logic                chk_v_q, chk_v_d;
	logic [VIRQ_W-1:0]   chk_idx_q, chk_idx_d;
	logic                chk_map_q;
	logic [NUM_VIRQ-1:0] enable_q;
	logic [NUM_VIRQ-1:0] mapped_q;
	logic                ge_q, ge_d;
	logic                out_v_q;
	res_t                out_q;
	res_t                res_d;
	logic                res_load;
	logic                can_load;
	logic                en_we;
	logic                map_we;

	logic                    ram_we;
	logic [VIRQ_W-1:0]       ram_waddr;
	logic [PHYS_ID_BITS-1:0] ram_wdata;
	logic                    ram_re;
	logic [VIRQ_W-1:0]       ram_raddr;
	logic [PHYS_ID_BITS-1:0] ram_rdata;

	logic [IW-1:0]           vid_x;
	logic [IW-1:0]           idx_x;
	logic [XW-1:0]           pid_in_x;
	logic [XW-1:0]           pid_cur_x;
	logic [XW-1:0]           rd_x;
	logic                    is_lu;
	logic                    set_op;
	logic                    bit_set;
	logic                    hit;
	logic                    stall;

	virqd_ram #(
		.WIDTH (PHYS_ID_BITS),
		.DEPTH (NUM_VIRQ)
	) u_phys_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign vid_x     = IW'(cmd.vid);
	assign idx_x     = IW'(chk_idx_q);
	assign pid_in_x  = XW'(cmd.pid);
	assign pid_cur_x = XW'(cur_q.pid);
	assign rd_x      = XW'(ram_rdata);
	assign ram_waddr = vid_x[VIRQ_W-1:0];
	assign ram_wdata = pid_in_x[PHYS_ID_BITS-1:0];
	assign ram_raddr = cnt_q[VIRQ_W-1:0];
	assign start     = CNT_W'(32'(cmd.word) << 5);

	assign can_load = !out_v_q || res_pop;
	assign is_lu    = (cur_q.cls == CLS_LOOKUP);
	assign set_op   = (cur_q.cls == CLS_EN_SET);
	assign bit_set  = cur_q.data[chk_idx_q[4:0]];
	// lookup matches the key; an enable sweep forwards set bits that are mapped
	assign hit      = chk_map_q &&
		(is_lu ? (ram_rdata == pid_cur_x[PHYS_ID_BITS-1:0]) : bit_set);
	assign stall    = chk_v_q && hit && !can_load;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		end_d     = end_q;
		chk_v_d   = chk_v_q;
		chk_idx_d = chk_idx_q;
		ge_d      = ge_q;
		cmd_pop   = 1'b0;
		cur_load  = 1'b0;
		res_load  = 1'b0;
		res_d     = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		en_we     = 1'b0;
		map_we    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_avail) begin
					unique case (cmd.cls) inside
						CLS_EN_SET, CLS_EN_CLR, CLS_LOOKUP: begin
							cmd_pop  = 1'b1;
							cur_load = 1'b1;
							chk_v_d  = 1'b0;
							state_d  = ST_SCAN;
							if (cmd.cls == CLS_LOOKUP) begin
								cnt_d = '0;
								end_d = CNT_W'(NUM_VIRQ);
							end else begin
								cnt_d = start;
								end_d = start + CNT_W'(32);
							end
						end
						CLS_READ, CLS_MAP, CLS_CTRL, CLS_DONE: begin
							if (can_load) begin
								cmd_pop      = 1'b1;
								res_load     = 1'b1;
								res_d.kind   = K_DONE;
								res_d.status = cmd.status;
								res_d.last   = 1'b1;
								if (cmd.cls == CLS_READ) begin
									res_d.kind      = K_READ;
									res_d.read_data = (cmd.status == S_OK) ? TYPE_VALUE : '0;
								end
								if (cmd.cls == CLS_MAP && cmd.status == S_OK) begin
									map_we = 1'b1;
									ram_we = cmd.pid_valid;
								end
								if (cmd.cls == CLS_CTRL && cmd.status == S_OK)
									ge_d = |cmd.data[1:0];
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					if (chk_v_q) begin
						if (!is_lu && bit_set)
							en_we = 1'b1;
						if (hit) begin
							res_load         = 1'b1;
							res_d.virq_index = idx_x[VIRQ_IDX_W-1:0];
							if (is_lu) begin
								res_d.kind     = K_LOOKUP;
								res_d.phys_irq = cur_q.pid;
								res_d.found    = 1'b1;
								res_d.last     = 1'b1;
							end else begin
								res_d.kind     = set_op ? K_FWD_EN : K_FWD_DIS;
								res_d.phys_irq = rd_x[PHYS_IRQ_W-1:0];
							end
						end
					end
					if (chk_v_q && hit && is_lu) begin
						chk_v_d = 1'b0;
						state_d = ST_IDLE;
					end else if (cnt_q != end_q) begin
						// read one entry per cycle while not stalled, checked the cycle after
						ram_re    = 1'b1;
						chk_idx_d = cnt_q[VIRQ_W-1:0];
						chk_v_d   = 1'b1;
						cnt_d     = cnt_q + 1'b1;
					end else begin
						chk_v_d = 1'b0;
						if (!chk_v_q)
							state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (can_load) begin
					res_load   = 1'b1;
					res_d.last = 1'b1;
					if (is_lu) begin
						res_d.kind     = K_LOOKUP;
						res_d.phys_irq = cur_q.pid;
					end else begin
						res_d.kind = K_DONE;
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		res_d.dist_enabled = ge_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			end_q    <= '0;
			chk_v_q  <= 1'b0;
			chk_idx_q <= '0;
			chk_map_q <= 1'b0;
			enable_q <= '0;
			mapped_q <= '0;
			ge_q     <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			end_q     <= end_d;
			chk_v_q   <= chk_v_d;
			chk_idx_q <= chk_idx_d;
			ge_q      <= ge_d;
			// mapped bit is fetched alongside the phys-id read
			if (ram_re)
				chk_map_q <= mapped_q[ram_raddr];
			if (en_we)
				enable_q[chk_idx_q] <= set_op;
			if (map_we)
				mapped_q[ram_waddr] <= cmd.pid_valid;
			if (res_load)
				out_v_q <= 1'b1;
			else if (res_pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cur_load)
			cur_q <= cmd;
		if (res_load)
			out_q <= res_d;
	end

	assign res       = out_q;
	assign res_valid = out_v_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == ST_IDLE)
		else $error("command taken while back end busy");

	a_chk_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_v_q |-> state_q == ST_SCAN)
		else $error("pending check outside a sweep");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= end_q)
		else $error("sweep counter past its end");

	a_fwd_en: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_d.kind == K_FWD_EN) |=> enable_q[$past(chk_idx_q)])
		else $error("forward enable without enable bit set");

endmodule

>>> design/virtual_irq_distributor.sv
// virtual_irq_distributor: top level of the virtual irq distributor
// depends on virqd_pkg, virqd_front, virqd_cmd_fifo and virqd_back
//
// Items enter through a push/full queue port and are decoded at once into a two-entry
// command queue; results leave through an empty/pop queue port, one result register deep.
// Register reads, map operations and writes other than set/clear-enable give one result. A
// set-enable or clear-enable word sweeps its 32 entries of the phys-id memory one per cycle
// (single read port) and emits its forwards as it goes. A reverse lookup sweeps the same
// memory from entry 0 and stops at the first hit. No clearing pass is needed after reset. A
// full result register holds the sweep until the result is taken.

module virtual_irq_distributor
	import virqd_pkg::*;
#(
	parameter int NUM_VIRQ     = NUM_VIRQ_DEF,
	parameter int PHYS_ID_BITS = PHYS_ID_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            operation,
	input  logic [11:0]           offset,
	input  logic [31:0]           data,
	input  logic [5:0]            vid,
	input  logic [9:0]            pid,
	input  logic                  pid_valid,
	output logic                  empty,
	input  logic                  pop,
	output logic [2:0]            kind,
	output logic [2:0]            status,
	output logic [31:0]           read_data,
	output logic [PHYS_IRQ_W-1:0] phys_irq,
	output logic                  found,
	output logic [VIRQ_IDX_W-1:0] virq_index,
	output logic                  dist_enabled,
	output logic                  last
);

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic q_push;
	logic q_full;
	logic q_avail;
	logic q_pop;
	res_t res;
	logic res_valid;

	virqd_front #(
		.NUM_VIRQ (NUM_VIRQ)
	) u_front (
		.push      (push),
		.full      (full),
		.operation (operation),
		.offset    (offset),
		.data      (data),
		.vid       (vid),
		.pid       (pid),
		.pid_valid (pid_valid),
		.q_full    (q_full),
		.q_push    (q_push),
		.cmd       (front_cmd)
	);

	virqd_cmd_fifo u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (front_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (head_cmd),
		.avail  (q_avail)
	);

	virqd_back #(
		.NUM_VIRQ     (NUM_VIRQ),
		.PHYS_ID_BITS (PHYS_ID_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_avail (q_avail),
		.cmd_pop   (q_pop),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	assign empty        = !res_valid;
	assign kind         = res.kind;
	assign status       = res.status;
	assign read_data    = res.read_data;
	assign phys_irq     = res.phys_irq;
	assign found        = res.found;
	assign virq_index   = res.virq_index;
	assign dist_enabled = res.dist_enabled;
	assign last         = res.last;

endmodule

>>> verif/testbench.sv
// testbench: self-checking bench for virtual_irq_distributor
// depends on virqd_pkg and the distributor rtl; keeps its own shadow of the enable, map and
// global enable state and checks every popped result against it

module testbench;
	import virqd_pkg::*;

	localparam int NUM_VIRQ = NUM_VIRQ_DEF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [1:0]            operation = OP_READ;
	logic [11:0]           offset = '0;
	logic [31:0]           data = '0;
	logic [5:0]            vid = '0;
	logic [9:0]            pid = '0;
	logic                  pid_valid = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [2:0]            kind;
	logic [2:0]            status;
	logic [31:0]           read_data;
	logic [PHYS_IRQ_W-1:0] phys_irq;
	logic                  found;
	logic [VIRQ_IDX_W-1:0] virq_index;
	logic                  dist_enabled;
	logic                  last;

	// shadow of the distributor state
	bit         sh_enable [NUM_VIRQ];
	bit         sh_mapped [NUM_VIRQ];
	logic [9:0] sh_phys [NUM_VIRQ];
	bit         sh_genable;

	res_t pending_results[$];
	int   fail_count = 0;
	int   push_idle_pct = 0;
	int   pop_idle_pct = 0;

	virtual_irq_distributor i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= pop_idle_pct);
	end

	function automatic void add_result(input logic [2:0] k, input logic [2:0] s,
		input logic [31:0] rd, input logic [9:0] ph, input logic f, input logic [5:0] vx,
		input logic lst);
		res_t r;
		r = {k, s, rd, ph, f, vx, sh_genable, lst};
		pending_results.push_back(r);
	endfunction

	// one bit per irq, forwards only for mapped irqs, ascending order
	function automatic logic [2:0] sweep_enable_word(input int word, input logic [31:0] dat,
		input bit set_op);
		int idx;
		if (word * 32 + 31 >= NUM_VIRQ)
			return S_RANGE;
		for (int i = 0; i < 32; i++) begin
			if (dat[i]) begin
				idx = word * 32 + i;
				sh_enable[idx] = set_op;
				if (sh_mapped[idx])
					add_result(set_op ? K_FWD_EN : K_FWD_DIS, S_OK, '0, sh_phys[idx], 1'b0,
						6'(idx), 1'b0);
			end
		end
		return S_OK;
	endfunction

	function automatic void mirror_item(input logic [1:0] op, input logic [11:0] ofs,
		input logic [31:0] dat, input logic [5:0] v, input logic [9:0] p, input logic pv);
		logic [2:0] st;
		bit         hit;
		int         o;
		st = S_OK;
		hit = 1'b0;
		o = int'(ofs);
		case (op)
			OP_READ: begin
				if (ofs == OFS_TYPE)
					add_result(K_READ, S_OK, TYPE_VALUE, '0, 1'b0, '0, 1'b1);
				else
					add_result(K_READ, S_BAD_OFFSET, '0, '0, 1'b0, '0, 1'b1);
			end
			OP_MAP: begin
				if (pv) begin
					sh_mapped[v] = 1'b1;
					sh_phys[v] = p;
				end else begin
					sh_mapped[v] = 1'b0;
				end
				add_result(K_DONE, S_OK, '0, '0, 1'b0, '0, 1'b1);
			end
			OP_LOOKUP: begin
				for (int i = 0; i < NUM_VIRQ && !hit; i++) begin
					if (sh_mapped[i] && sh_phys[i] == p) begin
						hit = 1'b1;
						add_result(K_LOOKUP, S_OK, '0, p, 1'b1, 6'(i), 1'b1);
					end
				end
				if (!hit)
					add_result(K_LOOKUP, S_OK, '0, p, 1'b0, '0, 1'b1);
			end
			default: begin
				if (ofs == OFS_CTRL) begin
					if (dat[0] && dat[1])
						st = S_BOTH_GROUPS;
					else
						sh_genable = dat[0] | dat[1];
				end else if (ofs == OFS_GROUP) begin
					st = S_OK;
				end else if (ofs >= OFS_SET_LO && ofs <= OFS_SET_HI) begin
					st = sweep_enable_word((o - int'(OFS_SET_LO)) / 4, dat, 1'b1);
				end else if (ofs >= OFS_CLR_LO && ofs <= OFS_CLR_HI) begin
					st = sweep_enable_word((o - int'(OFS_CLR_LO)) / 4, dat, 1'b0);
				end else if (ofs >= OFS_PRIO_LO && ofs <= OFS_PRIO_HI) begin
					st = S_OK;
				end else if (ofs >= OFS_TGT_LO && ofs <= OFS_TGT_HI) begin
					if ((o - int'(OFS_TGT_LO)) / 4 <= 7)
						st = S_BANKED;
				end else if (ofs >= OFS_CFG_LO && ofs <= OFS_CFG_HI) begin
					st = S_OK;
				end else if (ofs == OFS_SGI) begin
					if (dat[25:24] == 2'b11)
						st = S_BAD_SGI;
				end else begin
					st = S_BAD_OFFSET;
				end
				add_result(K_DONE, st, '0, '0, 1'b0, '0, 1'b1);
			end
		endcase
	endfunction

	// push stays high after a transfer so back-to-back items need no second assignment
	task automatic push_item(input logic [1:0] op, input logic [11:0] ofs,
		input logic [31:0] dat, input logic [5:0] v, input logic [9:0] p, input logic pv);
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		operation <= op;
		offset <= ofs;
		data <= dat;
		vid <= v;
		pid <= p;
		pid_valid <= pv;
		@(posedge clk);
		while (full)
			@(posedge clk);
		mirror_item(op, ofs, dat, v, p, pv);
	endtask

	task automatic reg_write(input logic [11:0] ofs, input logic [31:0] dat);
		push_item(OP_WRITE, ofs, dat, 6'($urandom), 10'($urandom), 1'($urandom));
	endtask

	task automatic reg_read(input logic [11:0] ofs);
		push_item(OP_READ, ofs, $urandom, 6'($urandom), 10'($urandom), 1'($urandom));
	endtask

	task automatic map_virq(input logic [5:0] v, input logic [9:0] p, input logic pv);
		push_item(OP_MAP, 12'($urandom), $urandom, v, p, pv);
	endtask

	task automatic lookup_pid(input logic [9:0] p);
		push_item(OP_LOOKUP, 12'($urandom), $urandom, 6'($urandom), p, 1'($urandom));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 100)
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_result
		res_t got;
		res_t want;
		if (arst_n && pop && !empty) begin
			got = {kind, status, read_data, phys_irq, found, virq_index, dist_enabled, last};
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing pending, expected none actual %0h", $time,
					got);
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("read_data", want.read_data, got.read_data);
				check_field("phys_irq", 32'(want.phys_irq), 32'(got.phys_irq));
				check_field("found", 32'(want.found), 32'(got.found));
				check_field("virq_index", 32'(want.virq_index), 32'(got.virq_index));
				check_field("dist_enabled", 32'(want.dist_enabled), 32'(got.dist_enabled));
				check_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	task automatic test_reads();
		reg_read(OFS_TYPE);
		reg_read(12'hFFF);
	endtask

	// both groups set must leave the enable as it was
	task automatic test_control();
		reg_write(OFS_CTRL, 32'h0000_0001);
		reg_write(OFS_CTRL, 32'hFFFF_FFFF);
		reg_write(OFS_CTRL, 32'h0000_0002);
		reg_write(OFS_CTRL, 32'h0000_0000);
	endtask

	task automatic test_map_lookup();
		map_virq(6'd0, 10'h3FF, 1'b1);
		map_virq(6'd31, 10'd5, 1'b1);
		map_virq(6'd32, 10'd0, 1'b1);
		map_virq(6'd63, 10'd5, 1'b1);
		lookup_pid(10'd5);
		map_virq(6'd31, 10'd5, 1'b0);
		lookup_pid(10'd5);
		lookup_pid(10'h2AA);
	endtask

	// global enable is off here, forwards must still appear
	task automatic test_enable_words();
		reg_write(OFS_SET_LO, 32'hFFFF_FFFF);
		reg_write(12'h107, 32'h8000_0001);
		reg_write(OFS_CLR_LO, 32'hFFFF_FFFF);
		reg_write(OFS_CLR_HI, 32'hFFFF_FFFF);
		reg_write(12'h108, 32'h0000_0001);
	endtask

	task automatic test_other_writes();
		reg_write(OFS_GROUP, $urandom);
		reg_write(OFS_PRIO_HI, $urandom);
		reg_write(12'h81C, $urandom);
		reg_write(12'h820, $urandom);
		reg_write(OFS_CFG_HI, $urandom);
		reg_write(OFS_SGI, 32'h0300_0000);
		reg_write(OFS_SGI, 32'h0100_0000);
		reg_write(12'h17D, $urandom);
	endtask

	// mostly maps and enable words so that words fill up with mapped irqs
	task automatic test_random(input int count);
		int         pick;
		logic [9:0] p;
		logic [11:0] ofs;
		logic [31:0] dat;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			p = $urandom_range(1) ? 10'($urandom_range(15)) : 10'($urandom);
			dat = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
			if (pick < 30) begin
				map_virq(6'($urandom), p, $urandom_range(99) < 85);
			end else if (pick < 60) begin
				ofs = $urandom_range(1) ? OFS_SET_LO : OFS_CLR_LO;
				if ($urandom_range(9) == 0)
					ofs = ofs + 12'($urandom_range(127));
				else
					ofs = ofs + 12'($urandom_range(7));
				reg_write(ofs, dat);
			end else if (pick < 75) begin
				lookup_pid(p);
			end else if (pick < 85) begin
				reg_write(OFS_CTRL, $urandom);
			end else if (pick < 90) begin
				reg_read($urandom_range(1) ? OFS_TYPE : 12'($urandom));
			end else begin
				case ($urandom_range(3))
					0: ofs = 12'($urandom);
					1: ofs = OFS_SGI;
					2: ofs = OFS_TGT_LO + 12'($urandom_range(255));
					default: ofs = OFS_PRIO_LO + 12'($urandom_range(1023));
				endcase
				reg_write(ofs, $urandom);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		push_idle_pct = 36;
		pop_idle_pct = 49;
		test_reads();
		test_control();
		test_map_lookup();
		test_enable_words();
		test_other_writes();
		test_random(61);
		wait_drained();
		push_idle_pct = 49;
		pop_idle_pct = 36;
		test_random(61);
		wait_drained();
		push_idle_pct = 0;
		pop_idle_pct = 0;
		test_random(61);
		wait_drained();
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
design/virqd_pkg.sv
design/virqd_ram.sv
design/virqd_cmd_fifo.sv
design/virqd_front.sv
design/virqd_back.sv
design/virtual_irq_distributor.sv
verif/testbench.sv
